FILE: design/assert_macros.svh
// Assertion macros shared by the RTL of the mouse packet tracker.
// Define NO_ASSERTIONS to compile every macro below to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checks that a condition holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Checks that a condition in one cycle implies another in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_ALWAYS(label, cond, msg)
`define ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

FILE: design/ps2mpt_pkg.sv
// Shared types and constants for the mouse packet tracker.
// Used by ps2mpt_axis and ps2_mouse_packet_tracker; depends on nothing.
package ps2mpt_pkg;

  // Width of a screen coordinate.
  localparam int COORD_BITS = 12;
  // Width of a screen size register.
  localparam int CFG_W = 13;
  // Width of the configuration register index.
  localparam int CFG_INDEX_W = 4;
  // Width of the arithmetic used for one axis update.
  localparam int AXIS_W = COORD_BITS + 2;
  // Width used to compare half a screen size against its limit.
  localparam int HALF_W = (CFG_W - 1 > COORD_BITS) ? CFG_W - 1 : COORD_BITS;
  // Largest half range that still keeps positions inside a coordinate.
  localparam logic [HALF_W-1:0] HALF_LIM = HALF_W'(1) << (COORD_BITS - 1);

  // Bit position of the always-one bit of a packet's first byte.
  localparam int SYNC_BIT = 3;

  // Reset sizes of the screen.
  localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(1024);
  localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(768);

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_WIDTH  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_HEIGHT = CFG_INDEX_W'(1);

  // Which byte of a packet is expected next.
  typedef enum logic [1:0] {
    PH_SYNC = 2'd0,
    PH_DX   = 2'd1,
    PH_DY   = 2'd2
  } phase_t;

  typedef logic signed [COORD_BITS-1:0] coord_t;

endpackage

FILE: design/ps2mpt_axis.sv
// One axis update of the mouse packet tracker: add or subtract a delta, then clamp.
// Depends on ps2mpt_pkg for widths and the half-range limit.
module ps2mpt_axis import ps2mpt_pkg::*; (
  input  coord_t            cur,
  input  logic signed [7:0] delta,
  input  logic              subtract,
  input  logic [CFG_W-1:0]  size,
  output coord_t            new_pos
);

  logic [HALF_W-1:0]        half_raw;
  logic [COORD_BITS-1:0]    half_sat;
  logic signed [AXIS_W-1:0] half_s;
  logic signed [AXIS_W-1:0] cur_ext;
  logic signed [AXIS_W-1:0] delta_ext;
  logic signed [AXIS_W-1:0] sum;
  logic signed [AXIS_W-1:0] upper;
  logic signed [AXIS_W-1:0] clamped;

  // Half of the screen size, limited so the range fits a coordinate.
  always_comb begin
    half_raw = HALF_W'(size[CFG_W-1:1]);
    if (half_raw > HALF_LIM) begin
      half_sat = HALF_LIM[COORD_BITS-1:0];
    end else begin
      half_sat = half_raw[COORD_BITS-1:0];
    end
    half_s = signed'({2'b00, half_sat});
  end

  // Move by the delta, then apply the upper bound before the lower one.
  always_comb begin
    cur_ext   = AXIS_W'(cur);
    delta_ext = AXIS_W'(delta);
    if (subtract) begin
      sum = cur_ext - delta_ext;
    end else begin
      sum = cur_ext + delta_ext;
    end
    if (sum >= half_s) begin
      upper = half_s - AXIS_W'(1);
    end else begin
      upper = sum;
    end
    if (upper <= -half_s) begin
      clamped = -half_s;
    end else begin
      clamped = upper;
    end
    new_pos = clamped[COORD_BITS-1:0];
  end

endmodule

FILE: design/ps2_mouse_packet_tracker.sv
// Mouse packet tracker: gathers raw mouse bytes into three-byte packets and
// tracks a clamped cursor position centered on the screen. It takes one byte
// per clock cycle unless stalled. Each byte is held in an input register, from
// which a packet's third byte writes its result into the output register. The
// input stalls only when a packet's last byte meets a result that is still
// waiting. A first byte with bit 3 clear is dropped to regain packet sync. The
// user must write the screen size registers through the cfg port only while
// no transaction is in flight; the block itself does not enforce this.
// Depends on ps2mpt_pkg, ps2mpt_axis and assert_macros.svh.
`include "assert_macros.svh"

module ps2_mouse_packet_tracker import ps2mpt_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  // Raw byte input
  input  logic                   data_valid,
  output logic                   data_ready,
  input  logic [7:0]             data_byte,
  // Result output
  output logic                   result_valid,
  input  logic                   result_ready,
  output coord_t                 pos_x,
  output coord_t                 pos_y,
  output coord_t                 prev_x,
  output coord_t                 prev_y,
  output logic [7:0]             pkt_status,
  // Configuration writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  logic             in_full;
  logic [7:0]       in_byte;
  phase_t           phase;
  phase_t           phase_next;
  logic [7:0]       held_status;
  logic [7:0]       held_dx;
  coord_t           cur_x;
  coord_t           cur_y;
  coord_t           last_x;
  coord_t           last_y;
  coord_t           new_x;
  coord_t           new_y;
  logic [CFG_W-1:0] screen_width;
  logic [CFG_W-1:0] screen_height;
  logic             adv;
  logic             emit;
  logic             take_status;
  logic             take_dx;

  // The held byte moves on unless it ends a packet and the output holds a result that is not being taken.
  assign adv        = in_full && ((phase != PH_DY) || !result_valid || result_ready);
  assign data_ready = !in_full || adv;
  assign cfg_ready  = 1'b1;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (data_ready) begin
      in_full <= data_valid;
    end
    if (data_valid && data_ready) begin
      in_byte <= data_byte;
    end
  end

  // Configuration registers; writes to unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= WIDTH_RESET;
      screen_height <= HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_SCREEN_WIDTH) begin
        screen_width <= cfg_data;
      end
      if (cfg_index == REG_SCREEN_HEIGHT) begin
        screen_height <= cfg_data;
      end
    end
  end

  // Packet phase: next state.
  always_comb begin
    phase_next = phase;
    if (adv) begin
      case (phase)
        PH_DX: begin
          phase_next = PH_DY;
        end
        PH_DY: begin
          phase_next = PH_SYNC;
        end
        default: begin
          phase_next = in_byte[SYNC_BIT] ? PH_DX : PH_SYNC;
        end
      endcase
    end
  end

  // Packet phase: actions taken on the held byte.
  always_comb begin
    emit        = 1'b0;
    take_status = 1'b0;
    take_dx     = 1'b0;
    if (adv) begin
      case (phase)
        PH_DX: begin
          take_dx = 1'b1;
        end
        PH_DY: begin
          emit = 1'b1;
        end
        default: begin
          take_status = in_byte[SYNC_BIT];
        end
      endcase
    end
  end

  // Axis updates: X adds its delta, Y subtracts it.
  ps2mpt_axis u_axis_x (
    .cur      (cur_x),
    .delta    (signed'(held_dx)),
    .subtract (1'b0),
    .size     (screen_width),
    .new_pos  (new_x)
  );

  ps2mpt_axis u_axis_y (
    .cur      (cur_y),
    .delta    (signed'(in_byte)),
    .subtract (1'b1),
    .size     (screen_height),
    .new_pos  (new_y)
  );

  // Packet state and position tracking.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_SYNC;
      held_status <= 8'd0;
      held_dx     <= 8'd0;
      cur_x       <= '0;
      cur_y       <= '0;
      last_x      <= '0;
      last_y      <= '0;
    end else begin
      phase <= phase_next;
      if (take_status) begin
        held_status <= in_byte;
      end
      if (take_dx) begin
        held_dx <= in_byte;
      end
      if (emit) begin
        cur_x  <= new_x;
        cur_y  <= new_y;
        last_x <= new_x;
        last_y <= new_y;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
    if (emit) begin
      pos_x      <= new_x;
      pos_y      <= new_y;
      prev_x     <= last_x;
      prev_y     <= last_y;
      pkt_status <= held_status;
    end
  end

  // The last byte of a packet always yields a result on the next edge.
  `ASSERT_NEXT(a_dy_emits, adv && (phase == PH_DY), result_valid,
               "packet end did not produce a result")
  // The X byte is always followed by a wait for the Y byte.
  `ASSERT_NEXT(a_dx_to_dy, adv && (phase == PH_DX), phase == PH_DY,
               "phase did not move from X byte to Y byte")
  // A held byte only stalls when it ends a packet and a result is waiting.
  `ASSERT_ALWAYS(a_stall_cause,
                 !(in_full && !adv) || ((phase == PH_DY) && result_valid && !result_ready),
                 "input register stalled without a waiting result")

endmodule
